FILE: hw/rtl/cbtc_pkg.sv
// cbtc_pkg: shared widths, constants and controller/datapath interface types
// for the CAN bit timing calculator. No dependencies.
package cbtc_pkg;

   // field widths
   localparam int RATE_W     = 20;
   localparam int CLOCK_W    = 29;
   localparam int PERIPH_W   = 28;
   localparam int BRP_W      = 10;
   localparam int QUANTA_W   = 9;
   localparam int SEG1_W     = 9;
   localparam int SEG2_W     = 8;
   localparam int SJW_W      = 7;
   localparam int WORD_W     = 32;
   localparam int CPB_W      = 32;

   // divider: 29-bit dividend, divisor up to 512 * (2^20 - 1)
   localparam int DIV_N_W    = 29;
   localparam int DIV_D_W    = 30;
   localparam int DIV_CNT_W  = 5;

   // search limit: quanta <= 384  <=>  periph < 385 * brp * rate
   localparam int LIM_W      = 39;
   localparam int STEP_W     = 29;

   localparam int QUANTA_MAX    = 384;
   localparam int QUANTA_LIMIT  = QUANTA_MAX + 1;
   localparam int QUANTA_MIN    = 3;
   localparam int SEG2_MAX      = 128;
   localparam int PRESCALER_MAX = 512;
   localparam int SJW_POS       = 25;
   localparam int BRP_POS       = 16;
   localparam int SEG1_POS      = 8;

   // x / 3 == (x * 171) >> 9 for x < 512
   localparam int DIV3_MUL   = 171;
   localparam int DIV3_SHIFT = 9;
   localparam int DIV3_W     = 16;

   localparam logic [CLOCK_W-1:0] CORE_CLOCK_RESET = CLOCK_W'(160000000);

   // configuration registers (word index)
   localparam logic REG_CORE_CLOCK = 1'b0;
   localparam int   CSR_ADDR_W     = 3;
   localparam int   CSR_DATA_W     = 32;

   // stream payload
   localparam int REQ_TDATA_W = 24;
   localparam int RSP_TDATA_W = 104;

   // divider operand select
   localparam logic DIV_SEL_QUANTA = 1'b0;
   localparam logic DIV_SEL_CLOCKS = 1'b1;

   typedef struct packed {
      logic load;         // take a new rate, reset the search
      logic search_step;  // next prescaler
      logic set_bad;      // request cannot be served
      logic div_start;
      logic div_sel;
      logic cap_quanta;
      logic cap_clocks;
      logic out_write;
   } cmd_type;

   typedef struct packed {
      logic rate_zero;
      logic fits;         // quanta at current prescaler <= 384
      logic brp_last;
      logic div_busy;
      logic out_free;
   } status_type;

endpackage

FILE: hw/rtl/cbtc_div.sv
// cbtc_div: restoring radix-2 divider, one quotient bit per cycle.
// Depends on cbtc_pkg.
module cbtc_div import cbtc_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [DIV_N_W-1:0] dividend,
   input  logic [DIV_D_W-1:0] divisor,
   output logic               busy,
   output logic [DIV_N_W-1:0] quotient
);

   logic                 busy_ff, busy_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [DIV_D_W:0]     rem_ff, rem_in;
   logic [DIV_N_W-1:0]   num_ff, num_in;
   logic [DIV_D_W-1:0]   den_ff, den_in;
   logic [DIV_D_W:0]     shifted;
   logic                 qbit;

   assign shifted = {rem_ff[DIV_D_W-1:0], num_ff[DIV_N_W-1]};
   assign qbit    = shifted >= {1'b0, den_ff};

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      num_in  = num_ff;
      den_in  = den_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = DIV_CNT_W'(DIV_N_W - 1);
         rem_in  = '0;
         num_in  = dividend;
         den_in  = divisor;
      end else if (busy_ff) begin
         rem_in = qbit ? (shifted - {1'b0, den_ff}) : shifted;
         num_in = {num_ff[DIV_N_W-2:0], qbit};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      num_ff <= num_in;
      den_ff <= den_in;
   end

   assign busy     = busy_ff;
   assign quotient = num_ff;

endmodule

FILE: hw/rtl/cbtc_datapath.sv
// cbtc_datapath: prescaler search, shared divider, segment split and
// result register. Depends on cbtc_pkg and cbtc_div.
module cbtc_datapath import cbtc_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  cmd_type                cmd,
   output status_type             status,
   input  logic [CLOCK_W-1:0]     core_clock,
   input  logic [RATE_W-1:0]      req_rate,
   input  logic                   rsp_ready,
   output logic                   rsp_valid,
   output logic [RSP_TDATA_W-1:0] rsp_data,
   output logic                   rsp_bad
);

   logic [RATE_W-1:0]   rate_ff, rate_in;
   logic [BRP_W-1:0]    brp_ff, brp_in;
   logic [DIV_D_W-1:0]  prod_ff, prod_in;     // brp * rate
   logic [STEP_W-1:0]   step_ff, step_in;     // 385 * rate
   logic [LIM_W-1:0]    lim_ff, lim_in;       // 385 * brp * rate
   logic                bad_ff, bad_in;
   logic [QUANTA_W-1:0] quanta_ff, quanta_in;
   logic [CLOCK_W-1:0]  clocks_ff, clocks_in;

   logic                   out_valid_ff, out_valid_in;
   logic [RSP_TDATA_W-1:0] out_data_ff, out_data_in;
   logic                   out_bad_ff, out_bad_in;

   logic [PERIPH_W-1:0] periph;
   logic [STEP_W-1:0]   step_new;
   logic [DIV_N_W-1:0]  div_n;
   logic [DIV_D_W-1:0]  div_d;
   logic                div_busy;
   logic [DIV_N_W-1:0]  div_q;

   logic                bad;
   logic [QUANTA_W-1:0] qm1;
   logic [DIV3_W-1:0]   third_prod;
   logic [SEG2_W-1:0]   third;
   logic [SEG2_W-1:0]   seg2;
   logic [SEG1_W-1:0]   seg1;
   logic [SJW_W-1:0]    sjw;
   logic [WORD_W-1:0]   word;

   assign periph   = core_clock[CLOCK_W-1:1];
   assign step_new = STEP_W'(req_rate) * STEP_W'(QUANTA_LIMIT);

   cbtc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (div_n),
      .divisor  (div_d),
      .busy     (div_busy),
      .quotient (div_q)
   );

   always_comb begin
      if (cmd.div_sel == DIV_SEL_CLOCKS) begin
         div_n = core_clock;
         div_d = DIV_D_W'(rate_ff);
      end else begin
         div_n = DIV_N_W'(periph);
         div_d = prod_ff;
      end
   end

   // search and capture registers
   always_comb begin
      rate_in   = rate_ff;
      brp_in    = brp_ff;
      prod_in   = prod_ff;
      step_in   = step_ff;
      lim_in    = lim_ff;
      bad_in    = bad_ff;
      quanta_in = quanta_ff;
      clocks_in = clocks_ff;
      if (cmd.load) begin
         rate_in = req_rate;
         brp_in  = BRP_W'(1);
         prod_in = DIV_D_W'(req_rate);
         step_in = step_new;
         lim_in  = LIM_W'(step_new);
         bad_in  = 1'b0;
      end
      if (cmd.search_step) begin
         brp_in  = brp_ff + 1'b1;
         prod_in = prod_ff + DIV_D_W'(rate_ff);
         lim_in  = lim_ff + LIM_W'(step_ff);
      end
      if (cmd.set_bad) begin
         bad_in = 1'b1;
      end
      if (cmd.cap_quanta) begin
         quanta_in = div_q[QUANTA_W-1:0];   // below 385 once the search fits
      end
      if (cmd.cap_clocks) begin
         clocks_in = div_q;
      end
   end

   // segment split
   assign bad        = bad_ff || (quanta_ff < QUANTA_W'(QUANTA_MIN));
   assign qm1        = quanta_ff - 1'b1;
   assign third_prod = DIV3_W'(qm1) * DIV3_W'(DIV3_MUL);
   assign third      = SEG2_W'(third_prod >> DIV3_SHIFT);

   always_comb begin
      if (third == '0) begin
         seg2 = SEG2_W'(1);
      end else if (third > SEG2_W'(SEG2_MAX)) begin
         seg2 = SEG2_W'(SEG2_MAX);
      end else begin
         seg2 = third;
      end
   end

   assign seg1 = qm1 - SEG1_W'(seg2);
   assign sjw  = SJW_W'(seg2 >> 1);
   assign word = (WORD_W'(sjw) << SJW_POS)
               | (WORD_W'(brp_ff - 1'b1) << BRP_POS)
               | (WORD_W'(seg1 - 1'b1) << SEG1_POS)
               | WORD_W'(seg2 - 1'b1);

   // result register
   always_comb begin
      out_valid_in = out_valid_ff;
      out_data_in  = out_data_ff;
      out_bad_in   = out_bad_ff;
      if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
      if (cmd.out_write) begin
         out_valid_in = 1'b1;
         out_bad_in   = bad;
         if (bad) begin
            out_data_in = '0;
         end else begin
            out_data_in = {6'b0, CPB_W'(clocks_ff), sjw, seg2, seg1, brp_ff, word};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
      rate_ff     <= rate_in;
      brp_ff      <= brp_in;
      prod_ff     <= prod_in;
      step_ff     <= step_in;
      lim_ff      <= lim_in;
      bad_ff      <= bad_in;
      quanta_ff   <= quanta_in;
      clocks_ff   <= clocks_in;
      out_data_ff <= out_data_in;
      out_bad_ff  <= out_bad_in;
   end

   assign status.rate_zero = (rate_ff == '0);
   assign status.fits      = LIM_W'(periph) < lim_ff;
   assign status.brp_last  = (brp_ff == BRP_W'(PRESCALER_MAX));
   assign status.div_busy  = div_busy;
   assign status.out_free  = !out_valid_ff || rsp_ready;

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;
   assign rsp_bad   = out_bad_ff;

endmodule

FILE: hw/rtl/cbtc_ctrl.sv
// cbtc_ctrl: sequencer for one request: zero check, prescaler search,
// two divisions, result hand-off. Depends on cbtc_pkg.
module cbtc_ctrl import cbtc_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_CHECK  = 3'd1;
   localparam logic [2:0] ST_SEARCH = 3'd2;
   localparam logic [2:0] ST_DIVQ   = 3'd3;
   localparam logic [2:0] ST_DIVC   = 3'd4;
   localparam logic [2:0] ST_FINISH = 3'd5;

   logic [2:0] state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (status.rate_zero) begin
               cmd.set_bad = 1'b1;
               state_in    = ST_FINISH;
            end else begin
               state_in = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            priority if (status.fits) begin
               cmd.div_start = 1'b1;
               cmd.div_sel   = DIV_SEL_QUANTA;
               state_in      = ST_DIVQ;
            end else if (status.brp_last) begin
               cmd.set_bad = 1'b1;
               state_in    = ST_FINISH;
            end else begin
               cmd.search_step = 1'b1;
            end
         end
         ST_DIVQ: begin
            if (!status.div_busy) begin
               cmd.cap_quanta = 1'b1;
               cmd.div_start  = 1'b1;
               cmd.div_sel    = DIV_SEL_CLOCKS;
               state_in       = ST_DIVC;
            end
         end
         ST_DIVC: begin
            cmd.div_sel = DIV_SEL_CLOCKS;
            if (!status.div_busy) begin
               cmd.cap_clocks = 1'b1;
               state_in       = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (status.out_free) begin
               cmd.out_write = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);

endmodule

FILE: hw/rtl/can_bit_timing_calculator_unit.sv
// can_bit_timing_calculator_unit: top level, stream ports, APB register,
// controller and datapath. Depends on cbtc_pkg, cbtc_ctrl, cbtc_datapath.
//
// Usage
//   req_*: one transaction per requested bit rate, bit_rate in tdata[19:0].
//   rsp_*: one transaction per request. tdata holds timing_word, prescaler,
//     seg_one, seg_two, jump_width and core_clocks_per_bit; tuser[0] is
//     bad_request, and a bad request returns all-zero tdata.
//   csr_*: APB register 0 at address 0 is core_clock_hz (29 bits, reset
//     160 MHz). Write it only while no request is in flight.
// Timing
//   One request at a time. After the accept the sequencer checks the rate,
//   tries one prescaler after another (1..512, linear search with an
//   incremental 385*brp*rate compare), then makes two passes of the shared
//   radix-2 divider (29 quotient bits each; quanta, then core clocks per
//   bit) and hands the result off. A zero rate skips the search and the
//   divides; an exhausted search skips the divides. req_tready is high only
//   while the sequencer is idle, so a new request is taken only after the
//   last one has been handed off to the output register.
// Reset and stall
//   reset returns the sequencer to idle, drops rsp_tvalid and reloads the
//   clock register. A result waiting on rsp_tready sits in the output
//   register; the next request is still accepted and computed, and is only
//   held back at the hand-off until the output register frees up.
module can_bit_timing_calculator_unit import cbtc_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   // request stream
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,   // [19:0] bit_rate, rest zero
   // result stream
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // [31:0] timing_word, [41:32] prescaler, [50:42] seg_one,
   // [58:51] seg_two, [65:59] jump_width, [97:66] core_clocks_per_bit
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   output logic                   rsp_tuser,   // [0] bad_request
   // register port
   input  logic                   csr_psel,
   input  logic                   csr_penable,
   input  logic                   csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [CSR_DATA_W-1:0]  csr_pwdata,
   output logic [CSR_DATA_W-1:0]  csr_prdata,
   output logic                   csr_pready
);

   logic [CLOCK_W-1:0] core_clock_ff, core_clock_in;
   logic               csr_wr;
   cmd_type            cmd;
   status_type         status;

   // register word index is paddr[2]; only index 0 exists
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      core_clock_in = core_clock_ff;
      if (csr_wr && (csr_paddr[2] == REG_CORE_CLOCK)) begin
         core_clock_in = csr_pwdata[CLOCK_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         core_clock_ff <= CORE_CLOCK_RESET;
      end else begin
         core_clock_ff <= core_clock_in;
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[2] == REG_CORE_CLOCK) begin
         csr_prdata = CSR_DATA_W'(core_clock_ff);
      end
   end

   cbtc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .status    (status),
      .cmd       (cmd)
   );

   cbtc_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .core_clock (core_clock_ff),
      .req_rate   (req_tdata[RATE_W-1:0]),
      .rsp_ready  (rsp_tready),
      .rsp_valid  (rsp_tvalid),
      .rsp_data   (rsp_tdata),
      .rsp_bad    (rsp_tuser)
   );

endmodule

FILE: hw/rtl/cbtc_checker.sv
// cbtc_checker: port-level assertions for the bit timing calculator, bound
// to the top level. Depends on cbtc_pkg and can_bit_timing_calculator_unit.
module cbtc_checker import cbtc_pkg::*; (
   input logic                   clock,
   input logic                   reset,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [RSP_TDATA_W-1:0] rsp_tdata,
   input logic                   rsp_tuser,
   input logic                   csr_pready
);

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   // rejected request carries no timing
   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata == '0)
      else $error("bad request with nonzero data");

   // packed word agrees with its prescaler and jump width; segments nonzero
   a_word_parts: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |->
         rsp_tdata[41:32] != 10'd0 && rsp_tdata[41:32] <= 10'd512 &&
         rsp_tdata[24:16] == 9'(rsp_tdata[41:32] - 10'd1) &&
         rsp_tdata[31:25] == rsp_tdata[65:59] &&
         rsp_tdata[58:51] != 8'd0 && rsp_tdata[50:42] != 9'd0)
      else $error("timing word does not match fields");

   a_pready: assert property (@(posedge clock) disable iff (reset) csr_pready)
      else $error("register port stalled");

endmodule

bind can_bit_timing_calculator_unit cbtc_checker u_cbtc_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .csr_pready (csr_pready)
);

FILE: dv/can_bit_timing_calculator_checker.sv
`timescale 1ns / 1ps
// can_bit_timing_calculator_checker: passive monitor for the bit timing unit.
// Tracks the clock register, predicts each result and compares it. Needs cbtc_pkg.
module can_bit_timing_calculator_checker import cbtc_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   input  logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   input  logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  logic [RSP_TDATA_W-1:0] rsp_tdata,
   input  logic                   rsp_tuser,
   input  logic                   csr_psel,
   input  logic                   csr_penable,
   input  logic                   csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [CSR_DATA_W-1:0]  csr_pwdata,
   input  logic [CSR_DATA_W-1:0]  csr_prdata,
   input  logic                   csr_pready,
   output int                     error_count,
   output int                     pending
);

   // declared MSB first so that the low bits line up with rsp_tdata
   typedef struct packed {
      logic              bad_request;
      logic [CPB_W-1:0]  core_clocks_per_bit;
      logic [SJW_W-1:0]  jump_width;
      logic [SEG2_W-1:0] seg_two;
      logic [SEG1_W-1:0] seg_one;
      logic [BRP_W-1:0]  prescaler;
      logic [WORD_W-1:0] timing_word;
   } bit_timing_type;

   localparam int FIELDS_W = $bits(bit_timing_type) - 1;

   logic [CLOCK_W-1:0] core_clock_hz;
   bit_timing_type     expected_timing[$];

   function automatic bit_timing_type compute_timing(input logic [CLOCK_W-1:0] core_hz,
                                                     input logic [RATE_W-1:0]  rate);
      bit_timing_type t;
      logic [63:0] periph, quanta, brp, seg1, seg2, sjw;
      t = '0;
      t.bad_request = 1'b1;
      periph = 64'(core_hz) >> 1;
      quanta = '0;
      brp = '0;
      if (rate == '0) return t;
      // linear prescaler search, first one that brings quanta to 384 or less
      for (int b = 1; b <= PRESCALER_MAX && brp == 0; b++) begin
         quanta = periph / (64'(b) * 64'(rate));
         if (quanta <= QUANTA_MAX) brp = 64'(b);
      end
      if (brp == 0 || quanta < QUANTA_MIN) return t;
      seg2 = (quanta - 1) / 3;
      if (seg2 > SEG2_MAX) seg2 = SEG2_MAX;
      if (seg2 < 1) seg2 = 1;
      seg1 = quanta - 1 - seg2;
      sjw = seg2 >> 1;
      t.timing_word = WORD_W'((sjw << SJW_POS) | ((brp - 1) << BRP_POS)
                              | ((seg1 - 1) << SEG1_POS) | (seg2 - 1));
      t.prescaler = BRP_W'(brp);
      t.seg_one = SEG1_W'(seg1);
      t.seg_two = SEG2_W'(seg2);
      t.jump_width = SJW_W'(sjw);
      t.core_clocks_per_bit = CPB_W'(64'(core_hz) / 64'(rate));
      t.bad_request = 1'b0;
      return t;
   endfunction

   task automatic compare_field(input string name, input logic [63:0] want,
                                input logic [63:0] got);
      if (want !== got) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         error_count++;
      end
   endtask

   always @(posedge clock) begin : monitor
      bit_timing_type want, got;
      if (reset) begin
         core_clock_hz = CORE_CLOCK_RESET;
         expected_timing.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pready
             && csr_paddr[CSR_ADDR_W-1:2] == REG_CORE_CLOCK) begin
            if (csr_pwrite)
               core_clock_hz = csr_pwdata[CLOCK_W-1:0];
            else
               compare_field("core_clock_hz", 64'(core_clock_hz), 64'(csr_prdata));
         end
         if (req_tvalid && req_tready)
            expected_timing.push_back(compute_timing(core_clock_hz, req_tdata[RATE_W-1:0]));
         if (rsp_tvalid && rsp_tready) begin
            got = {rsp_tuser, rsp_tdata[FIELDS_W-1:0]};
            if (expected_timing.size() == 0) begin
               $error("result transaction with no request outstanding");
               error_count++;
            end else begin
               want = expected_timing.pop_front();
               compare_field("timing_word", 64'(want.timing_word), 64'(got.timing_word));
               compare_field("prescaler", 64'(want.prescaler), 64'(got.prescaler));
               compare_field("seg_one", 64'(want.seg_one), 64'(got.seg_one));
               compare_field("seg_two", 64'(want.seg_two), 64'(got.seg_two));
               compare_field("jump_width", 64'(want.jump_width), 64'(got.jump_width));
               compare_field("core_clocks_per_bit", 64'(want.core_clocks_per_bit),
                             64'(got.core_clocks_per_bit));
               compare_field("bad_request", 64'(want.bad_request), 64'(got.bad_request));
               compare_field("tdata padding", '0, 64'(rsp_tdata[RSP_TDATA_W-1:FIELDS_W]));
            end
         end
      end
      pending = expected_timing.size();
   end

endmodule

FILE: dv/can_bit_timing_calculator_unit_test.sv
`timescale 1ns / 1ps
// can_bit_timing_calculator_unit_test: stimulus and verdict for the bit timing
// unit. Needs cbtc_pkg, the unit and can_bit_timing_calculator_checker.
module can_bit_timing_calculator_unit_test;
   import cbtc_pkg::*;

   localparam int PERIOD        = 10;
   localparam int RANDOM_PHASES = 5;
   localparam int PHASE_ITEMS   = 20;
   localparam int HOLD_AT       = 30;    // result index where the sink backs off
   localparam int HOLD_CYCLES   = 400;   // long enough to fill the output register
   localparam int TAIL_CYCLES   = 600;   // about one worst-case search plus divides
   localparam int QUIET_LIMIT   = 5000;  // cycles without any transaction

   // register addresses: word index times four
   localparam logic [CSR_ADDR_W-1:0] CLOCK_ADDR = CSR_ADDR_W'(REG_CORE_CLOCK) << 2;
   localparam logic [CSR_ADDR_W-1:0] SPARE_ADDR = CLOCK_ADDR + CSR_ADDR_W'(4);
   localparam logic                  CSR_WRITE  = 1'b1;
   localparam logic                  CSR_READ   = 1'b0;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;   // [19:0] bit_rate
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   // [31:0] timing_word, [41:32] prescaler, [50:42] seg_one,
   // [58:51] seg_two, [65:59] jump_width, [97:66] core_clocks_per_bit
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   rsp_tuser;        // [0] bad_request
   logic                   csr_psel = 1'b0;
   logic                   csr_penable = 1'b0;
   logic                   csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0]  csr_paddr = '0;
   logic [CSR_DATA_W-1:0]  csr_pwdata = '0;
   logic [CSR_DATA_W-1:0]  csr_prdata;
   logic                   csr_pready;

   int error_count;
   int pending;

   // idling switches, flipped per phase by the stimulus process
   bit req_idle_on = 1'b1;
   bit rsp_idle_on = 1'b1;

   always #(PERIOD / 2) clock = ~clock;

   can_bit_timing_calculator_unit dut (.*);

   can_bit_timing_calculator_checker timing_check (.*);

   // ---------------------------------------------------------------------
   // Request side
   // ---------------------------------------------------------------------

   // Offer one rate and return at the edge where it is accepted. A gap, if
   // drawn, drops tvalid first; with no gap tvalid stays high back to back.
   task automatic send_rate(input logic [RATE_W-1:0] rate);
      int gap;
      gap = req_idle_on ? $urandom_range(0, 4) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_TDATA_W'(rate);
      @(posedge clock);
      while (req_tready !== 1'b1) @(posedge clock);
   endtask

   // Stop offering and wait until every expected result has been taken, so
   // the block is idle and the register may be written.
   task automatic drain();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending != 0);
   endtask

   // One APB transfer: setup, then access until pready. psel is left high so
   // that transfers can follow back to back; csr_release ends the burst.
   task automatic csr_access(input logic [CSR_ADDR_W-1:0] addr, input logic write,
                             input logic [CSR_DATA_W-1:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= write;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (csr_pready !== 1'b1) @(posedge clock);
   endtask

   task automatic csr_release();
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // New clock setting: the write to the spare address must not touch the
   // clock register, and the read back shows the value masked to 29 bits.
   task automatic set_core_clock(input logic [CSR_DATA_W-1:0] value);
      csr_access(CLOCK_ADDR, CSR_WRITE, value);
      csr_access(SPARE_ADDR, CSR_WRITE, $urandom());
      csr_access(CLOCK_ADDR, CSR_READ, '0);
      csr_release();
   endtask

   // Most often the usual CAN rates, then any legal rate, the full 20-bit field,
   // very low rates, some of which run the prescaler out, and the odd zero.
   function automatic logic [RATE_W-1:0] random_rate();
      int pick;
      logic [RATE_W-1:0] rate;
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
         case ($urandom_range(0, 9))
            0:       rate = RATE_W'(10000);
            1:       rate = RATE_W'(20000);
            2:       rate = RATE_W'(50000);
            3:       rate = RATE_W'(83333);
            4:       rate = RATE_W'(100000);
            5:       rate = RATE_W'(125000);
            6:       rate = RATE_W'(250000);
            7:       rate = RATE_W'(500000);
            8:       rate = RATE_W'(800000);
            default: rate = RATE_W'(1000000);
         endcase
      end else if (pick < 70) begin
         rate = RATE_W'($urandom_range(1, 1000000));
      end else if (pick < 85) begin
         rate = RATE_W'($urandom());
      end else if (pick < 95) begin
         rate = RATE_W'($urandom_range(1, 2000));
      end else begin
         rate = '0;
      end
      return rate;
   endfunction

   // Core clocks across the legal range and common crystal values; the last
   // phase takes a raw 32-bit word to exercise the register mask.
   function automatic logic [CSR_DATA_W-1:0] random_clock(input int phase);
      logic [CSR_DATA_W-1:0] value;
      if (phase == RANDOM_PHASES - 1) begin
         value = $urandom();
      end else if ($urandom_range(0, 2) == 0) begin
         case ($urandom_range(0, 5))
            0:       value = 8000000;
            1:       value = 16000000;
            2:       value = 48000000;
            3:       value = 80000000;
            4:       value = 120000000;
            default: value = 240000000;
         endcase
      end else begin
         value = $urandom_range(1000000, 400000000);
      end
      return value;
   endfunction

   initial begin : stimulus
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // reset value of the clock register
      csr_access(CLOCK_ADDR, CSR_READ, '0);
      csr_release();

      // at the reset clock: zero rate, prescaler run out, the top of the
      // 20-bit field, and both sides of the 384-quanta boundary
      send_rate('0);
      send_rate(RATE_W'(1));
      send_rate('1);
      send_rate(RATE_W'(1000000));
      send_rate(RATE_W'(500000));
      send_rate(RATE_W'(125000));
      send_rate(RATE_W'(1000));
      send_rate(RATE_W'(208333));
      send_rate(RATE_W'(207792));
      drain();

      // slowest legal clock: exactly three quanta (segment 2 clamped up),
      // too few quanta, four quanta, and an exhausted search
      set_core_clock(1000000);
      send_rate(RATE_W'(166666));
      send_rate(RATE_W'(250000));
      send_rate(RATE_W'(125000));
      send_rate(RATE_W'(1));
      drain();

      // fastest legal clock
      set_core_clock(400000000);
      send_rate(RATE_W'(1));
      send_rate(RATE_W'(1000000));
      drain();

      // clock below 2 Hz: peripheral clock is zero
      set_core_clock(1);
      send_rate(RATE_W'(500000));
      drain();

      // all ones: only the low 29 bits stick
      set_core_clock('1);
      send_rate('1);
      send_rate(RATE_W'(3));
      drain();

      // random phases; idling is switched off on one side or both in some of
      // them, and the result sink backs off for a long stretch in the first
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         req_idle_on = (phase % 2) == 0;
         rsp_idle_on = phase != 1;
         set_core_clock(random_clock(phase));
         repeat (PHASE_ITEMS) send_rate(random_rate());
         drain();
      end

      repeat (TAIL_CYCLES) @(posedge clock);
      if (error_count == 0 && pending == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Result side: random gaps, sometimes before and sometimes after tvalid
   // shows up, plus one long hold-off while requests keep coming.
   // ---------------------------------------------------------------------
   initial begin : result_sink
      int gap;
      int taken;
      taken = 0;
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         gap = rsp_idle_on ? $urandom_range(0, 4) : 0;
         if (taken == HOLD_AT) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else if (gap > 0) begin
            rsp_tready <= 1'b0;
            if ($urandom_range(0, 1) == 1) begin
               @(posedge clock);
               while (rsp_tvalid !== 1'b1) @(posedge clock);
            end
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (rsp_tvalid !== 1'b1) @(posedge clock);
         taken++;
      end
   end

   // ---------------------------------------------------------------------
   // Watchdog: any transaction on any port counts as progress.
   // ---------------------------------------------------------------------
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
             || (csr_psel && csr_penable))
            quiet = 0;
         else
            quiet++;
      end
      $display("DONE: errors detected");
      $finish;
   end

endmodule

FILE: sim.f
hw/rtl/cbtc_pkg.sv
hw/rtl/cbtc_div.sv
hw/rtl/cbtc_datapath.sv
hw/rtl/cbtc_ctrl.sv
hw/rtl/can_bit_timing_calculator_unit.sv
hw/rtl/cbtc_checker.sv
dv/can_bit_timing_calculator_checker.sv
dv/can_bit_timing_calculator_unit_test.sv
